// ===== rtl/distinct_prime_sum_counter_assert.svh =====
// Assertion macros for the distinct prime sum counter.
`ifndef DISTINCT_PRIME_SUM_COUNTER_ASSERT_SVH
`define DISTINCT_PRIME_SUM_COUNTER_ASSERT_SVH

`ifndef SYNTH
`define DPSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dpsc assertion failed");
`define DPSC_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("dpsc assertion failed");
`else
`define DPSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DPSC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/dpsc_pkg.sv =====
// Shared widths and parameter defaults for the distinct prime sum counter.
package dpsc_pkg;
    localparam int DPSC_MAX_SUM   = 1024;
    localparam int DPSC_MAX_PARTS = 16;
    localparam int SUM_W          = 11;
    localparam int PARTS_W        = 5;
    localparam int COUNT_W        = 32;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 32;
endpackage

// ===== rtl/dpsc_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
module dpsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

// ===== rtl/dpsc_builder.sv =====
// Table builder: clear sweep, prime sieve and descending knapsack passes.
module dpsc_builder #(
    parameter int MAX_SUM   = dpsc_pkg::DPSC_MAX_SUM,
    parameter int MAX_PARTS = dpsc_pkg::DPSC_MAX_PARTS
) (
    input  logic                                          clk,
    input  logic                                          rstn,
    output logic                                          table_ready,
    output logic                                          tbl_re_a,
    output logic [$clog2((MAX_SUM+1)*(MAX_PARTS+1))-1:0]  tbl_addr_a,
    input  logic [dpsc_pkg::COUNT_W-1:0]                  tbl_rdata_a,
    output logic                                          tbl_re_b,
    output logic [$clog2((MAX_SUM+1)*(MAX_PARTS+1))-1:0]  tbl_addr_b,
    input  logic [dpsc_pkg::COUNT_W-1:0]                  tbl_rdata_b,
    output logic                                          tbl_we,
    output logic [$clog2((MAX_SUM+1)*(MAX_PARTS+1))-1:0]  tbl_waddr,
    output logic [dpsc_pkg::COUNT_W-1:0]                  tbl_wdata
);
    import dpsc_pkg::*;

    localparam int ROW_LEN    = MAX_PARTS + 1;
    localparam int TBL_DEPTH  = (MAX_SUM + 1) * ROW_LEN;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int MARK_DEPTH = MAX_SUM + 1;
    localparam int MARK_AW    = $clog2(MARK_DEPTH);
    localparam int M_W        = $clog2(2 * MAX_SUM + 1);
    localparam int C_W        = $clog2(MAX_PARTS + 1);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_SV_RD  = 7'b0000010,
        ST_SV_CHK = 7'b0000100,
        ST_MARK   = 7'b0001000,
        ST_KNAP   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } bld_state_t;

    bld_state_t         state_reg, state_next;
    logic [TBL_AW-1:0]  clr_reg, clr_next;
    logic [MARK_AW-1:0] i_reg, i_next;
    logic [TBL_AW-1:0]  ofs_reg, ofs_next;
    logic [M_W-1:0]     m_reg, m_next;
    logic [TBL_AW-1:0]  dst_reg, dst_next;
    logic [TBL_AW-1:0]  src_reg, src_next;
    logic [C_W-1:0]     c_reg, c_next;
    logic               wv_reg, wv_next;
    logic [TBL_AW-1:0]  wa_reg, wa_next;

    logic               mark_we;
    logic [MARK_AW-1:0] mark_waddr;
    logic               mark_re;
    logic [0:0]         mark_rdata;
    logic [M_W-1:0]     m_step;
    logic [M_W-1:0]     m_dbl;
    logic [COUNT_W:0]   sat_sum;

    dpsc_ram #(
        .WIDTH (1),
        .DEPTH (MARK_DEPTH)
    ) u_mark_ram (
        .clk     (clk),
        .we      (mark_we),
        .waddr   (mark_waddr),
        .wdata   (state_reg == ST_MARK),
        .re_a    (mark_re),
        .raddr_a (i_reg),
        .rdata_a (mark_rdata),
        .re_b    (1'b0),
        .raddr_b ('0),
        .rdata_b ()
    );

    assign m_step  = m_reg + M_W'(i_reg);
    assign m_dbl   = M_W'(i_reg) << 1;
    assign sat_sum = {1'b0, tbl_rdata_a} + {1'b0, tbl_rdata_b};
    assign table_ready = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        ofs_next   = ofs_reg;
        m_next     = m_reg;
        dst_next   = dst_reg;
        src_next   = src_reg;
        c_next     = c_reg;
        wv_next    = 1'b0;
        wa_next    = wa_reg;
        mark_we    = 1'b0;
        mark_waddr = m_reg[MARK_AW-1:0];
        mark_re    = 1'b0;
        tbl_re_a   = 1'b0;
        tbl_addr_a = dst_reg;
        tbl_re_b   = 1'b0;
        tbl_addr_b = src_reg;
        tbl_we     = wv_reg;
        tbl_waddr  = wa_reg;
        tbl_wdata  = sat_sum[COUNT_W] ? '1 : sat_sum[COUNT_W-1:0];

        case (state_reg)
            ST_CLEAR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = clr_reg;
                tbl_wdata  = (clr_reg == '0) ? COUNT_W'(1) : '0;
                mark_we    = (clr_reg < TBL_AW'(MARK_DEPTH));
                mark_waddr = clr_reg[MARK_AW-1:0];
                if (clr_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    state_next = ST_SV_RD;
                    i_next     = MARK_AW'(2);
                    ofs_next   = TBL_AW'(2 * ROW_LEN);
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_SV_RD: begin
                mark_re    = 1'b1;
                state_next = ST_SV_CHK;
            end
            ST_SV_CHK: begin
                if (mark_rdata[0]) begin
                    if (i_reg == MARK_AW'(MAX_SUM)) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        ofs_next   = ofs_reg + TBL_AW'(ROW_LEN);
                        state_next = ST_SV_RD;
                    end
                end else if (m_dbl > M_W'(MAX_SUM)) begin
                    dst_next   = TBL_AW'(TBL_DEPTH - 1);
                    src_next   = TBL_AW'(TBL_DEPTH - 2) - ofs_reg;
                    c_next     = C_W'(MAX_PARTS);
                    state_next = ST_KNAP;
                end else begin
                    m_next     = m_dbl;
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                mark_we = 1'b1;
                m_next  = m_step;
                if (m_step > M_W'(MAX_SUM)) begin
                    dst_next   = TBL_AW'(TBL_DEPTH - 1);
                    src_next   = TBL_AW'(TBL_DEPTH - 2) - ofs_reg;
                    c_next     = C_W'(MAX_PARTS);
                    state_next = ST_KNAP;
                end
            end
            ST_KNAP: begin
                tbl_re_a = 1'b1;
                tbl_re_b = 1'b1;
                wv_next  = 1'b1;
                wa_next  = dst_reg;
                if (dst_reg == ofs_reg + 1'b1) begin
                    state_next = ST_DRAIN;
                end else if (c_reg == C_W'(1)) begin
                    c_next   = C_W'(MAX_PARTS);
                    dst_next = dst_reg - TBL_AW'(2);
                    src_next = src_reg - TBL_AW'(2);
                end else begin
                    c_next   = c_reg - 1'b1;
                    dst_next = dst_reg - 1'b1;
                    src_next = src_reg - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_reg == MARK_AW'(MAX_SUM)) begin
                    state_next = ST_DONE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    ofs_next   = ofs_reg + TBL_AW'(ROW_LEN);
                    state_next = ST_SV_RD;
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            wv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wv_reg    <= wv_next;
        end
        i_reg   <= i_next;
        ofs_reg <= ofs_next;
        m_reg   <= m_next;
        dst_reg <= dst_next;
        src_reg <= src_next;
        c_reg   <= c_next;
        wa_reg  <= wa_next;
    end
endmodule

// ===== rtl/dpsc_query.sv =====
// Query pipeline: table address, range check and output register.
module dpsc_query #(
    parameter int MAX_SUM   = dpsc_pkg::DPSC_MAX_SUM,
    parameter int MAX_PARTS = dpsc_pkg::DPSC_MAX_PARTS
) (
    input  logic                                          clk,
    input  logic                                          rstn,
    input  logic                                          table_ready,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [dpsc_pkg::SUM_W-1:0]                    s_target_sum,
    input  logic [dpsc_pkg::PARTS_W-1:0]                  s_part_count,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [dpsc_pkg::COUNT_W-1:0]                  m_way_count,
    output logic                                          rd_en,
    output logic [$clog2((MAX_SUM+1)*(MAX_PARTS+1))-1:0]  rd_addr,
    input  logic [dpsc_pkg::COUNT_W-1:0]                  rd_data
);
    import dpsc_pkg::*;

    localparam int ROW_LEN   = MAX_PARTS + 1;
    localparam int TBL_DEPTH = (MAX_SUM + 1) * ROW_LEN;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic               pend_reg;
    logic               hit_reg;
    logic               valid_reg;
    logic [COUNT_W-1:0] data_reg;
    logic               accept;
    logic               advance;
    logic               hit;

    assign advance  = pend_reg && (!valid_reg || m_tready);
    assign s_tready = table_ready && (!pend_reg || advance);
    assign accept   = s_tvalid && s_tready;

    assign hit = (s_target_sum != '0) && (s_part_count != '0)
              && ({1'b0, s_target_sum} <= (SUM_W + 1)'(MAX_SUM))
              && ({1'b0, s_part_count} <= (PARTS_W + 1)'(MAX_PARTS));

    assign rd_en   = accept;
    assign rd_addr = TBL_AW'(s_target_sum) * TBL_AW'(ROW_LEN) + TBL_AW'(s_part_count);

    assign m_tvalid    = valid_reg;
    assign m_way_count = data_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (advance) begin
                pend_reg <= 1'b0;
            end
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            hit_reg <= hit;
        end
        if (advance) begin
            data_reg <= hit_reg ? rd_data : '0;
        end
    end
endmodule

// ===== rtl/distinct_prime_sum_counter.sv =====
// Distinct prime sum counter: counts sets of distinct primes with a given sum and size.
// After reset the table is built before any query: a clear sweep of all (MAX_SUM+1)*(MAX_PARTS+1)
// entries, a read and a check per sieve candidate, a mark write per multiple of each prime,
// and a knapsack pass for each prime p over the entries of sum p and above.
// Then one query per cycle unless the output stalls; results pass the RAM read and output registers.
// The table is not rebuilt until the next reset.
`include "distinct_prime_sum_counter_assert.svh"

module distinct_prime_sum_counter #(
    parameter int MAX_SUM   = dpsc_pkg::DPSC_MAX_SUM,
    parameter int MAX_PARTS = dpsc_pkg::DPSC_MAX_PARTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [10:0] target_sum, [15:11] part_count
    input  logic [dpsc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] way_count
    output logic [dpsc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dpsc_pkg::*;

    localparam int TBL_DEPTH = (MAX_SUM + 1) * (MAX_PARTS + 1);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic               table_ready;
    logic               bld_re_a;
    logic [TBL_AW-1:0]  bld_addr_a;
    logic               bld_re_b;
    logic [TBL_AW-1:0]  bld_addr_b;
    logic               bld_we;
    logic [TBL_AW-1:0]  bld_waddr;
    logic [COUNT_W-1:0] bld_wdata;
    logic               q_rd_en;
    logic [TBL_AW-1:0]  q_rd_addr;
    logic               re_a;
    logic [TBL_AW-1:0]  addr_a;
    logic [COUNT_W-1:0] rdata_a;
    logic [COUNT_W-1:0] rdata_b;

    assign re_a   = table_ready ? q_rd_en : bld_re_a;
    assign addr_a = table_ready ? q_rd_addr : bld_addr_a;

    dpsc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TBL_DEPTH)
    ) u_table_ram (
        .clk     (aclk),
        .we      (bld_we),
        .waddr   (bld_waddr),
        .wdata   (bld_wdata),
        .re_a    (re_a),
        .raddr_a (addr_a),
        .rdata_a (rdata_a),
        .re_b    (bld_re_b),
        .raddr_b (bld_addr_b),
        .rdata_b (rdata_b)
    );

    dpsc_builder #(
        .MAX_SUM   (MAX_SUM),
        .MAX_PARTS (MAX_PARTS)
    ) u_builder (
        .clk         (aclk),
        .rstn        (aresetn),
        .table_ready (table_ready),
        .tbl_re_a    (bld_re_a),
        .tbl_addr_a  (bld_addr_a),
        .tbl_rdata_a (rdata_a),
        .tbl_re_b    (bld_re_b),
        .tbl_addr_b  (bld_addr_b),
        .tbl_rdata_b (rdata_b),
        .tbl_we      (bld_we),
        .tbl_waddr   (bld_waddr),
        .tbl_wdata   (bld_wdata)
    );

    dpsc_query #(
        .MAX_SUM   (MAX_SUM),
        .MAX_PARTS (MAX_PARTS)
    ) u_query (
        .clk          (aclk),
        .rstn         (aresetn),
        .table_ready  (table_ready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_target_sum (s_tdata[SUM_W-1:0]),
        .s_part_count (s_tdata[SUM_W+PARTS_W-1:SUM_W]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_way_count  (m_tdata),
        .rd_en        (q_rd_en),
        .rd_addr      (q_rd_addr),
        .rd_data      (rdata_a)
    );

    `DPSC_ASSERT_IMP(a_no_query_during_build, aclk, aresetn, s_tvalid && s_tready, table_ready)
    `DPSC_ASSERT_NEVER(a_ready_holds, aclk, aresetn, $fell(table_ready))
    `DPSC_ASSERT_IMP(a_src_no_overlap, aclk, aresetn, bld_we && bld_re_b, bld_addr_b != bld_waddr)
    `DPSC_ASSERT_IMP(a_dst_no_overlap, aclk, aresetn, bld_we && bld_re_a, bld_addr_a != bld_waddr)
endmodule
